FILE: hdl/vks_pkg.sv
// vks_pkg: constants, register codes and helper functions for the vehicle kinematics step
// no dependencies
package vks_pkg;

    localparam int unsigned TRIG_TABLE_BITS = 10;
    localparam logic signed [47:0] FWD_SPEED_LIMIT = 48'sd1310720;
    localparam logic signed [47:0] REV_SPEED_LIMIT = 48'sd327680;

    // quarter-wave polynomial coefficients, q16
    localparam logic [16:0] SIN_C1 = 17'd102944;
    localparam logic [15:0] SIN_C3 = 16'd42047;
    localparam logic [15:0] SIN_C5 = 16'd4639;
    localparam logic [15:0] RAD_TO_BAM = 16'd10430;
    localparam logic [17:0] TRIG_ONE = 18'd65536;
    localparam logic [15:0] TRIG_MASK = ~16'((1 << (16 - TRIG_TABLE_BITS)) - 1);

    // register indexes
    localparam logic [2:0] REG_TIME_STEP = 3'd0;
    localparam logic [2:0] REG_ACCEL_LIMIT = 3'd1;
    localparam logic [2:0] REG_STEER_LIMIT = 3'd2;
    localparam logic [2:0] REG_ACCEL_SLEW = 3'd3;
    localparam logic [2:0] REG_STEER_SLEW = 3'd4;
    localparam logic [2:0] REG_DRAG_FACTOR = 3'd5;
    localparam logic [2:0] REG_GRIP_FACTOR = 3'd6;
    localparam logic [2:0] REG_TURN_GAIN = 3'd7;

    typedef logic signed [31:0] t_fix32;
    typedef logic signed [15:0] t_fix16;

    function automatic t_fix32 sat32(input logic signed [63:0] v);
        t_fix32 r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // slew limit then magnitude clamp, all values fit 18 bits signed
    function automatic t_fix16 slew_clamp(input t_fix16 tgt, input t_fix16 now,
                                          input logic [14:0] slew, input logic [14:0] lim);
        logic signed [17:0] d;
        logic signed [17:0] sl;
        logic signed [17:0] li;
        logic signed [17:0] v;
        d = 18'(tgt) - 18'(now);
        sl = $signed({3'b000, slew});
        li = $signed({3'b000, lim});
        if (d > sl) begin
            d = sl;
        end else if (d < -sl) begin
            d = -sl;
        end
        v = 18'(now) + d;
        if (v > li) begin
            v = li;
        end else if (v < -li) begin
            v = -li;
        end
        return v[15:0];
    endfunction

endpackage

FILE: hdl/vehicle_kinematics_step_top.sv
// vehicle_kinematics_step_top: one simulation tick per input transfer, single shared multiplier
// depends on vks_pkg
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    accel_target, steer_target, car_alive
//  result    out        o_valid / i_stall    pos, vel, heading, speed, accel, steer, time
//  config    in         apb psel/penable     eight registers at 4*index
//
// a live tick takes the transfer, then runs 33 multiplications on the one 44x18 multiplier,
// each in an issue phase and a write-back phase, then presents the result
// a tick with car_alive low goes straight to the result
// o_stall is high from the accepted transfer until the result transfer completes
// the result is held in the state registers while i_stall is high
// synchronous active-low reset loads register defaults and clears the sequencer and vehicle state
module vehicle_kinematics_step_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  vks_pkg::t_fix16      i_accel_target,
    input  vks_pkg::t_fix16      i_steer_target,
    input  logic                 i_car_alive,
    output logic                 o_valid,
    input  logic                 i_stall,
    output vks_pkg::t_fix32      o_pos_x,
    output vks_pkg::t_fix32      o_pos_y,
    output vks_pkg::t_fix32      o_vel_x,
    output vks_pkg::t_fix32      o_vel_y,
    output logic [15:0]          o_heading_out,
    output vks_pkg::t_fix32      o_forward_speed,
    output vks_pkg::t_fix16      o_applied_accel,
    output vks_pkg::t_fix16      o_applied_steer,
    output logic [31:0]          o_alive_time,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import vks_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;
    localparam logic [5:0] LAST_STEP = 6'd32;

    // configuration
    logic [15:0] r_time_step, r_drag, r_grip, r_gain;
    logic [14:0] r_accel_lim, r_steer_lim, r_accel_slew, r_steer_slew;

    // architectural state
    t_fix16      r_accel, r_steer;
    logic [15:0] r_head;
    t_fix32      r_vx, r_vy, r_speed, r_px, r_py;
    logic [31:0] r_time;

    // sequencer
    logic [1:0] r_state;
    logic [5:0] r_step;
    logic       r_ph;

    // datapath temporaries
    logic signed [61:0] r_prod, r_acc;
    logic        [14:0] r_z2;
    logic        [15:0] r_inn;
    logic        [16:0] r_mid;
    logic signed [17:0] r_c, r_s;
    logic signed [43:0] r_ta, r_tb, r_wx, r_wy;

    logic w_in_xfer, w_out_xfer, w_cfg_wr;
    logic [15:0] w_ac, w_as;
    logic [14:0] w_tc, w_ts, w_t;
    logic        w_neg;
    logic signed [43:0] w_a;
    logic signed [17:0] w_b;
    logic signed [62:0] w_sum, w_dif;
    logic signed [46:0] w_sum16, w_dif16;
    logic signed [45:0] w_sh16;
    logic signed [53:0] w_sh8;
    logic signed [47:0] w_sh14;
    logic        [17:0] w_q14, w_lim;
    logic signed [47:0] w_cl;

    // clamped speed always lies inside the 32-bit range
    function automatic t_fix32 r_cl_trunc(input logic signed [47:0] v);
        return v[31:0];
    endfunction

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite;
    assign o_stall    = (r_state != ST_IDLE);
    assign o_valid    = (r_state == ST_OUT);
    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_xfer = o_valid && !i_stall;

    assign o_pos_x         = r_px;
    assign o_pos_y         = r_py;
    assign o_vel_x         = r_vx;
    assign o_vel_y         = r_vy;
    assign o_heading_out   = r_head;
    assign o_forward_speed = r_speed;
    assign o_applied_accel = r_accel;
    assign o_applied_steer = r_steer;
    assign o_alive_time    = r_time;

    always_comb begin
        case (paddr[4:2])
            REG_TIME_STEP:   prdata = {16'd0, r_time_step};
            REG_ACCEL_LIMIT: prdata = {17'd0, r_accel_lim};
            REG_STEER_LIMIT: prdata = {17'd0, r_steer_lim};
            REG_ACCEL_SLEW:  prdata = {17'd0, r_accel_slew};
            REG_STEER_SLEW:  prdata = {17'd0, r_steer_slew};
            REG_DRAG_FACTOR: prdata = {16'd0, r_drag};
            REG_GRIP_FACTOR: prdata = {16'd0, r_grip};
            REG_TURN_GAIN:   prdata = {16'd0, r_gain};
            default:         prdata = 32'd0;
        endcase
    end

    // quarter-wave argument for cos (heading plus a quarter turn) and sin
    assign w_ac = (r_head + 16'd16384) & TRIG_MASK;
    assign w_as = r_head & TRIG_MASK;
    assign w_tc = w_ac[14] ? (15'd16384 - {1'b0, w_ac[13:0]}) : {1'b0, w_ac[13:0]};
    assign w_ts = w_as[14] ? (15'd16384 - {1'b0, w_as[13:0]}) : {1'b0, w_as[13:0]};
    // steps 0..3 evaluate cos, 4..7 sin
    assign w_t   = (r_step < 6'd4) ? w_tc : w_ts;
    assign w_neg = (r_step < 6'd4) ? w_ac[15] : w_as[15];

    // operand selection for the shared multiplier
    always_comb begin
        case (r_step)
            6'd0, 6'd4:   begin w_a = 44'($signed({1'b0, w_t}));   w_b = 18'($signed({1'b0, w_t})); end
            6'd1, 6'd5:   begin w_a = 44'($signed({1'b0, r_z2}));  w_b = 18'($signed({1'b0, SIN_C5})); end
            6'd2, 6'd6:   begin w_a = 44'($signed({1'b0, r_z2}));  w_b = 18'($signed({1'b0, r_inn})); end
            6'd3, 6'd7:   begin w_a = 44'($signed({1'b0, w_t}));   w_b = $signed({1'b0, r_mid}); end
            6'd8:         begin w_a = 44'(r_accel); w_b = r_c; end
            6'd10:        begin w_a = 44'(r_accel); w_b = r_s; end
            6'd9, 6'd11, 6'd29: begin
                w_a = r_ta; w_b = 18'($signed({1'b0, r_time_step}));
            end
            6'd12:        begin w_a = r_wx; w_b = 18'($signed({1'b0, r_drag})); end
            6'd13:        begin w_a = r_wy; w_b = 18'($signed({1'b0, r_drag})); end
            6'd14, 6'd23: begin w_a = r_wx; w_b = r_c; end
            6'd15, 6'd24: begin w_a = r_wy; w_b = r_s; end
            6'd16:        begin w_a = r_wy; w_b = r_c; end
            6'd17:        begin w_a = r_wx; w_b = r_s; end
            6'd18:        begin w_a = r_tb; w_b = 18'($signed({1'b0, r_grip})); end
            6'd19, 6'd25: begin w_a = r_ta; w_b = r_c; end
            6'd20:        begin w_a = r_tb; w_b = r_s; end
            6'd21, 6'd26: begin w_a = r_ta; w_b = r_s; end
            6'd22:        begin w_a = r_tb; w_b = r_c; end
            6'd27:        begin w_a = 44'(r_speed); w_b = 18'(r_steer); end
            6'd28:        begin w_a = r_ta; w_b = 18'($signed({1'b0, r_gain})); end
            6'd30:        begin w_a = r_ta; w_b = 18'($signed({1'b0, RAD_TO_BAM})); end
            6'd31:        begin w_a = 44'(r_vx); w_b = 18'($signed({1'b0, r_time_step})); end
            6'd32:        begin w_a = 44'(r_vy); w_b = 18'($signed({1'b0, r_time_step})); end
            default:      begin w_a = 44'sd0; w_b = 18'sd0; end
        endcase
    end

    // write-back helpers, all shifts round toward minus infinity
    assign w_sum   = 63'(r_acc) + 63'(r_prod);
    assign w_dif   = 63'(r_acc) - 63'(r_prod);
    assign w_sum16 = 47'(w_sum >>> 16);
    assign w_dif16 = 47'(w_dif >>> 16);
    assign w_sh16  = 46'(r_prod >>> 16);
    assign w_sh14  = 48'(r_prod >>> 14);
    assign w_sh8   = 54'(r_prod >>> 8);
    assign w_q14   = r_prod[31:14];
    assign w_lim   = (w_q14 > TRIG_ONE) ? TRIG_ONE : w_q14;
    assign w_cl    = (48'(w_sum16) > FWD_SPEED_LIMIT) ? FWD_SPEED_LIMIT :
                     (48'(w_sum16) < -REV_SPEED_LIMIT) ? -REV_SPEED_LIMIT : 48'(w_sum16);

    // multiplier and temporaries
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN && !r_ph) begin
            r_prod <= 62'(w_a * w_b);
        end
        if (r_state == ST_RUN && r_ph) begin
            case (r_step)
                6'd0, 6'd4: r_z2  <= r_prod[28:14];
                6'd1, 6'd5: r_inn <= SIN_C3 - r_prod[29:14];
                6'd2, 6'd6: r_mid <= SIN_C1 - r_prod[30:14];
                6'd3:       r_c   <= w_neg ? -$signed(w_lim) : $signed(w_lim);
                6'd7:       r_s   <= w_neg ? -$signed(w_lim) : $signed(w_lim);
                6'd8, 6'd10: r_ta <= 44'(w_sh8);
                6'd9:       r_wx  <= 44'(r_vx) + 44'(w_sh16);
                6'd11:      r_wy  <= 44'(r_vy) + 44'(w_sh16);
                6'd12:      r_wx  <= 44'(sat32(64'(w_sh16)));
                6'd13:      r_wy  <= 44'(sat32(64'(w_sh16)));
                6'd14, 6'd16, 6'd19, 6'd21, 6'd23: r_acc <= r_prod;
                6'd15:      r_ta  <= 44'(w_sum16);
                6'd17:      r_tb  <= 44'(w_dif16);
                6'd18:      r_tb  <= 44'(w_sh16);
                6'd20:      r_wx  <= 44'(sat32(64'(w_dif16)));
                6'd22:      r_wy  <= 44'(sat32(64'(w_sum16)));
                6'd24:      r_ta  <= 44'(w_cl - 48'(w_sum16));
                6'd27:      r_ta  <= 44'(w_sh14);
                6'd28:      r_ta  <= 44'(w_sh8);
                6'd29:      r_ta  <= 44'(w_sh16);
                default:    r_acc <= r_acc;
            endcase
        end
    end

    // control, configuration and vehicle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= 6'd0;
            r_ph         <= 1'b0;
            r_time_step  <= 16'd1092;
            r_accel_lim  <= 15'd2560;
            r_steer_lim  <= 15'd8192;
            r_accel_slew <= 15'd256;
            r_steer_slew <= 15'd1638;
            r_drag       <= 16'd64880;
            r_grip       <= 16'd58982;
            r_gain       <= 16'd256;
            r_accel      <= '0;
            r_steer      <= '0;
            r_head       <= '0;
            r_vx         <= '0;
            r_vy         <= '0;
            r_speed      <= '0;
            r_px         <= '0;
            r_py         <= '0;
            r_time       <= '0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[4:2])
                    REG_TIME_STEP:   r_time_step  <= pwdata[15:0];
                    REG_ACCEL_LIMIT: r_accel_lim  <= pwdata[14:0];
                    REG_STEER_LIMIT: r_steer_lim  <= pwdata[14:0];
                    REG_ACCEL_SLEW:  r_accel_slew <= pwdata[14:0];
                    REG_STEER_SLEW:  r_steer_slew <= pwdata[14:0];
                    REG_DRAG_FACTOR: r_drag       <= pwdata[15:0];
                    REG_GRIP_FACTOR: r_grip       <= pwdata[15:0];
                    REG_TURN_GAIN:   r_gain       <= pwdata[15:0];
                    default:         r_gain       <= r_gain;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_step <= 6'd0;
                        r_ph   <= 1'b0;
                        if (i_car_alive) begin
                            // slew and clamp happen on the accepting edge
                            r_accel <= slew_clamp(i_accel_target, r_accel,
                                                  r_accel_slew, r_accel_lim);
                            r_steer <= slew_clamp(i_steer_target, r_steer,
                                                  r_steer_slew, r_steer_lim);
                            r_state <= ST_RUN;
                        end else begin
                            // dead car: report current state unchanged
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_RUN: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        case (r_step)
                            6'd24: r_speed <= r_cl_trunc(w_cl);
                            6'd25: r_vx    <= sat32(64'(r_wx) + 64'(w_sh16));
                            6'd26: r_vy    <= sat32(64'(r_wy) + 64'(w_sh16));
                            6'd30: r_head  <= r_head + r_prod[31:16];
                            6'd31: r_px    <= sat32(64'(r_px) + 64'(w_sh16));
                            6'd32: begin
                                r_py   <= sat32(64'(r_py) + 64'(w_sh16));
                                r_time <= (33'(r_time) + 33'(r_time_step) > 33'h0ffffffff)
                                          ? 32'hffffffff : r_time + 32'(r_time_step);
                            end
                            default: begin
                            end
                        endcase
                        if (r_step == LAST_STEP) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_step <= r_step + 6'd1;
                        end
                    end
                end
                ST_OUT: begin
                    if (w_out_xfer) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/vks_checker.sv
// vks_checker: port-level checks on the vehicle kinematics step, bound to the top level
// depends on vks_pkg and vehicle_kinematics_step_top
module vks_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 i_car_alive,
    input logic                 o_valid,
    input logic                 i_stall,
    input vks_pkg::t_fix32      o_pos_x,
    input vks_pkg::t_fix32      o_vel_x,
    input logic [31:0]          o_alive_time
);
    import vks_pkg::*;

    // a waiting result is held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pos_x) && $stable(o_alive_time))
        else $error("result changed while stalled");

    // no new tick is taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");

    // a dead tick reports the state as it was
    a_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_car_alive |=>
            o_valid && $stable(o_pos_x) && $stable(o_vel_x) && $stable(o_alive_time))
        else $error("dead tick changed state");

    // one result per tick
    a_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("result repeated");

endmodule

bind vehicle_kinematics_step_top vks_checker u_vks_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_car_alive  (i_car_alive),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_pos_x      (o_pos_x),
    .o_vel_x      (o_vel_x),
    .o_alive_time (o_alive_time)
);

FILE: tb/tb.sv
// tb: self-checking testbench for vehicle_kinematics_step_top
// depends on vks_pkg and the block; predicts each tick's state and checks every result
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vks_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 900000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    t_fix16      i_accel_target = '0;
    t_fix16      i_steer_target = '0;
    logic        i_car_alive = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_fix32      o_pos_x, o_pos_y, o_vel_x, o_vel_y, o_forward_speed;
    logic [15:0] o_heading_out;
    t_fix16      o_applied_accel, o_applied_steer;
    logic [31:0] o_alive_time;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    vehicle_kinematics_step_top dut (.*);

    always #5 i_clk = ~i_clk;

    // one result transfer
    typedef struct packed {
        logic [31:0] pos_x, pos_y, vel_x, vel_y;
        logic [15:0] heading;
        logic [31:0] speed;
        logic [15:0] accel, steer;
        logic [31:0] alive_time;
    } car_state_t;

    // predictor copy of the registers and car state
    logic [15:0] m_dt, m_drag, m_grip, m_turn;
    logic [14:0] m_alim, m_slim, m_aslew, m_sslew;
    longint      m_acc, m_str, m_vx, m_vy, m_spd, m_px, m_py;
    logic [15:0] m_head;
    longint unsigned m_time;

    car_state_t  expected_states[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    int          results_seen = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;  // arithmetic shift rounds toward minus infinity
    endfunction

    function automatic longint sat_s32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint limit_range(longint v, longint lo, longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint quarter_wave(longint t);
        longint z2, inner, mid, r;
        z2 = (t * t) >> 14;
        inner = 42047 - ((z2 * 4639) >> 14);
        mid = 102944 - ((z2 * inner) >> 14);
        r = (t * mid) >> 14;
        if (r > 65536) r = 65536;
        return r;
    endfunction

    function automatic longint sine_of(logic [15:0] a);
        logic [15:0] t;
        longint v;
        t = a & TRIG_MASK;
        v = t[14] ? quarter_wave(16384 - longint'(t[13:0])) : quarter_wave(longint'(t[13:0]));
        return t[15] ? -v : v;
    endfunction

    function automatic car_state_t snapshot();
        car_state_t r;
        r.pos_x = m_px[31:0];  r.pos_y = m_py[31:0];
        r.vel_x = m_vx[31:0];  r.vel_y = m_vy[31:0];
        r.heading = m_head;    r.speed = m_spd[31:0];
        r.accel = m_acc[15:0]; r.steer = m_str[15:0];
        r.alive_time = m_time[31:0];
        return r;
    endfunction

    // advance the car by one tick
    task automatic advance_car(input t_fix16 acc_t, input t_fix16 str_t, input logic alive);
        longint dt, d, c, s, vx, vy, vf, vl, cl, turn;
        if (alive) begin
            dt = longint'(m_dt);
            d = limit_range(longint'(acc_t) - m_acc, -longint'(m_aslew), longint'(m_aslew));
            m_acc = limit_range(m_acc + d, -longint'(m_alim), longint'(m_alim));
            d = limit_range(longint'(str_t) - m_str, -longint'(m_sslew), longint'(m_sslew));
            m_str = limit_range(m_str + d, -longint'(m_slim), longint'(m_slim));
            c = sine_of(m_head + 16'd16384);
            s = sine_of(m_head);
            vx = m_vx + floor_shr(floor_shr(m_acc * c, 8) * dt, 16);
            vy = m_vy + floor_shr(floor_shr(m_acc * s, 8) * dt, 16);
            vx = sat_s32(floor_shr(vx * longint'(m_drag), 16));
            vy = sat_s32(floor_shr(vy * longint'(m_drag), 16));
            vf = floor_shr(vx * c + vy * s, 16);
            vl = floor_shr(vy * c - vx * s, 16);
            vl = floor_shr(vl * longint'(m_grip), 16);
            vx = sat_s32(floor_shr(vf * c - vl * s, 16));
            vy = sat_s32(floor_shr(vf * s + vl * c, 16));
            vf = floor_shr(vx * c + vy * s, 16);
            cl = limit_range(vf, -327680, 1310720);
            d = cl - vf;
            m_vx = sat_s32(vx + floor_shr(d * c, 16));
            m_vy = sat_s32(vy + floor_shr(d * s, 16));
            m_spd = sat_s32(cl);
            turn = floor_shr(m_str * m_spd, 14);
            turn = floor_shr(turn * longint'(m_turn), 8);
            turn = floor_shr(turn * dt, 16);
            turn = floor_shr(turn * 10430, 16);
            m_head = m_head + turn[15:0];
            m_px = sat_s32(m_px + floor_shr(m_vx * dt, 16));
            m_py = sat_s32(m_py + floor_shr(m_vy * dt, 16));
            m_time = m_time + longint'(m_dt);
            if (m_time > 64'hFFFFFFFF) m_time = 64'hFFFFFFFF;
        end
        expected_states.push_back(snapshot());
    endtask

    // send one tick; the expectation is queued at acceptance
    // the block is busy after a transfer, so the task first waits for a clock edge
    task automatic send_tick(input t_fix16 acc_t, input t_fix16 str_t, input logic alive);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_valid <= 1'b1;
        i_accel_target <= acc_t;
        i_steer_target <= str_t;
        i_car_alive <= alive;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        advance_car(acc_t, str_t, alive);
        i_valid <= 1'b0;
        i_accel_target <= t_fix16'($urandom);
        i_steer_target <= t_fix16'($urandom);
        i_car_alive <= 1'($urandom);
    endtask

    task automatic drain();
        while (expected_states.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // apb write with setup and access phases, plus a read-back
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        mask = (idx inside {REG_TIME_STEP, REG_DRAG_FACTOR, REG_GRIP_FACTOR, REG_TURN_GAIN})
               ? 32'hFFFF : 32'h7FFF;
        if ((prdata & mask) != (val & mask)) begin
            $error("register %0d read-back: expected %0h actual %0h", idx, val & mask, prdata);
            fail_count++;
        end
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_TIME_STEP:   m_dt = val[15:0];
            REG_ACCEL_LIMIT: m_alim = val[14:0];
            REG_STEER_LIMIT: m_slim = val[14:0];
            REG_ACCEL_SLEW:  m_aslew = val[14:0];
            REG_STEER_SLEW:  m_sslew = val[14:0];
            REG_DRAG_FACTOR: m_drag = val[15:0];
            REG_GRIP_FACTOR: m_grip = val[15:0];
            default:         m_turn = val[15:0];
        endcase
    endtask

    task automatic write_all(input logic [31:0] v[8]);
        for (int i = 0; i < 8; i++) write_reg(3'(i), v[i]);
    endtask

    // extremes of the fields, dead ticks, slew and clamp edges at reset settings
    task automatic test_directed();
        send_tick(16'sh7fff, 16'sh7fff, 1'b1);
        send_tick(-16'sh8000, -16'sh8000, 1'b1);
        send_tick(16'sh7fff, 16'sh7fff, 1'b0);
        for (int i = 0; i < 8; i++) send_tick(16'sh0a00, 16'sh2000, 1'b1);
        send_tick(16'sh0000, 16'sh0000, 1'b1);
        send_tick(-16'sh0a00, -16'sh2000, 1'b1);
        send_tick(16'shffff, 16'sh5555, 1'b1);
        send_tick(16'sh5555, 16'shaaaa, 1'b0);
        drain();
    endtask

    // big turn gain and step to wrap the heading and hit speed clamps, then all-zero settings
    task automatic test_extreme_settings();
        logic [31:0] v[8];
        v = '{32'hFFFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'h7FFF, 32'hFFFF, 32'hFFFF, 32'hFFFF};
        write_all(v);
        for (int i = 0; i < 12; i++) send_tick(16'sh7fff, 16'sh7fff, 1'b1);
        for (int i = 0; i < 12; i++) send_tick(-16'sh8000, -16'sh8000, 1'b1);
        drain();
        v = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
        write_all(v);
        for (int i = 0; i < 4; i++) send_tick(t_fix16'($urandom), t_fix16'($urandom), 1'b1);
        drain();
    endtask

    // random ticks, mostly alive, under one idling profile
    task automatic test_random_phase(input int n, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < n; i++)
            send_tick(t_fix16'($urandom), t_fix16'($urandom), $urandom_range(9) != 0);
        drain();
    endtask

    // random settings, then a random run
    task automatic test_random_settings(input int send_pct, input int recv_pct);
        logic [31:0] v[8];
        for (int i = 0; i < 8; i++) v[i] = $urandom;
        write_all(v);
        test_random_phase(150, send_pct, recv_pct);
    endtask

    // check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        car_state_t e;
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            if (o_valid && !i_stall) begin
                if (expected_states.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end else begin
                    e = expected_states.pop_front();
                    results_seen++;
                    if (o_pos_x !== e.pos_x) begin
                        $error("pos_x: expected %0h actual %0h", e.pos_x, o_pos_x);
                        fail_count++;
                    end
                    if (o_pos_y !== e.pos_y) begin
                        $error("pos_y: expected %0h actual %0h", e.pos_y, o_pos_y);
                        fail_count++;
                    end
                    if (o_vel_x !== e.vel_x) begin
                        $error("vel_x: expected %0h actual %0h", e.vel_x, o_vel_x);
                        fail_count++;
                    end
                    if (o_vel_y !== e.vel_y) begin
                        $error("vel_y: expected %0h actual %0h", e.vel_y, o_vel_y);
                        fail_count++;
                    end
                    if (o_heading_out !== e.heading) begin
                        $error("heading_out: expected %0h actual %0h", e.heading, o_heading_out);
                        fail_count++;
                    end
                    if (o_forward_speed !== e.speed) begin
                        $error("forward_speed: expected %0h actual %0h", e.speed,
                               o_forward_speed);
                        fail_count++;
                    end
                    if (o_applied_accel !== e.accel) begin
                        $error("applied_accel: expected %0h actual %0h", e.accel,
                               o_applied_accel);
                        fail_count++;
                    end
                    if (o_applied_steer !== e.steer) begin
                        $error("applied_steer: expected %0h actual %0h", e.steer,
                               o_applied_steer);
                        fail_count++;
                    end
                    if (o_alive_time !== e.alive_time) begin
                        $error("alive_time: expected %0h actual %0h", e.alive_time,
                               o_alive_time);
                        fail_count++;
                    end
                end
            end
            // receiver stall for the next edge
            i_stall <= ($urandom_range(99) < recv_stall_pct);
            if (cycle_count > CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        // reset values of the registers
        m_dt = 16'd1092;  m_alim = 15'd2560; m_slim = 15'd8192; m_aslew = 15'd256;
        m_sslew = 15'd1638; m_drag = 16'd64880; m_grip = 16'd58982; m_turn = 16'd256;
        m_acc = 0; m_str = 0; m_head = '0; m_vx = 0; m_vy = 0; m_spd = 0;
        m_px = 0; m_py = 0; m_time = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_extreme_settings();
        test_random_settings(0, 0);
        test_random_settings(82, 0);
        test_random_settings(0, 82);
        test_random_settings(9, 9);
        // large time step, drag, accel limit and slew with reset turn gain, then a long run
        write_reg(REG_TIME_STEP, 32'hFFFF);
        write_reg(REG_TURN_GAIN, 32'h0100);
        write_reg(REG_DRAG_FACTOR, 32'hFFFF);
        write_reg(REG_ACCEL_LIMIT, 32'h7FFF);
        write_reg(REG_ACCEL_SLEW, 32'h7FFF);
        test_random_phase(240, 0, 0);
        test_random_phase(150, 9, 9);
        drain();
        $display("covered %0d result transfers over directed, extreme and random settings",
                 results_seen);
        $display("idling phases: none, sender 82%%, receiver 82%%, both 9%%");
        if (fail_count == 0 && expected_states.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
